// ===== rtl/hhnc_pkg.sv =====
`default_nettype none

package hhnc_pkg;

	localparam int NUM_KINDS = 52;
	localparam int MAX_NAME  = 32;
	localparam int BYTE_W    = 8;
	localparam int POS_W     = 6;
	localparam int KIND_W    = 6;
	localparam int NAME_W    = MAX_NAME * BYTE_W;

	// Known names in kind order, kind 1 first. Each literal is right-aligned in its
	// word, with zero bytes in the unused upper part.
	localparam logic [NAME_W-1:0] KNOWN_NAMES [NUM_KINDS] = '{
		"age", "date", "etag", "link", "vary", "range", ":path", "cookie",
		"origin", "server", "accept", "alt-svc", ":method", ":scheme", "purpose",
		"referer", ":status", "if-range", "location", "forwarded", "expect-ct",
		"early-data", "set-cookie", "user-agent", ":authority", "content-type",
		"last-modified", "if-none-match", "cache-control", "authorization",
		"accept-ranges", "content-length", "accept-language", "accept-encoding",
		"x-forwarded-for", "x-frame-options", "content-encoding",
		"x-xss-protection", "if-modified-since", "content-disposition",
		"timing-allow-origin", "x-content-type-options",
		"content-security-policy", "upgrade-insecure-requests",
		"strict-transport-security", "access-control-allow-origin",
		"access-control-allow-headers", "access-control-allow-methods",
		"access-control-request-method", "access-control-expose-headers",
		"access-control-request-headers", "access-control-allow-credentials"
	};

	function automatic logic [POS_W-1:0] name_len(input int k);
		logic [NAME_W-1:0] s;
		logic [POS_W-1:0]  n;
		s = KNOWN_NAMES[k];
		n = '0;
		for (int i = 0; i < MAX_NAME; i++) begin
			if (s[BYTE_W*i +: BYTE_W] != '0) begin
				n = n + POS_W'(1);
			end
		end
		return n;
	endfunction

	// The name moved to the top of the word, so that its first byte is the top byte.
	function automatic logic [NAME_W-1:0] name_left(input int k);
		return KNOWN_NAMES[k] << (BYTE_W * (MAX_NAME - int'(name_len(k))));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hhnc_match.sv =====
`default_nettype none

module hhnc_match (
	input  wire logic [hhnc_pkg::BYTE_W-1:0]    name_byte,
	input  wire logic [4:0]                     pos,
	input  wire logic [hhnc_pkg::POS_W-1:0]     next_pos,
	output logic      [hhnc_pkg::NUM_KINDS-1:0] keep,
	output logic      [hhnc_pkg::NUM_KINDS-1:0] ends
);
	import hhnc_pkg::*;

	for (genvar k = 0; k < NUM_KINDS; k++) begin : g_kind
		localparam logic [NAME_W-1:0] NameLeft = name_left(k);
		localparam logic [POS_W-1:0]  NameLen  = name_len(k);
		logic [BYTE_W-1:0] want;

		// Byte at position pos counts down from the top of the left-aligned word.
		assign want    = NameLeft[{~pos, 3'b000} +: BYTE_W];
		assign keep[k] = (want != '0) && (want == name_byte);
		assign ends[k] = (next_pos == NameLen);
	end

endmodule

`default_nettype wire

// ===== rtl/http_header_name_classifier.sv =====
// A byte is registered at the input on acceptance, and the kind for a final byte is registered
// at the output when that byte moves on, which waits while the result register is blocked.
// Throughput: one name byte per cycle unless a final byte waits on a blocked result register;
// the mask update is combinational, so consecutive bytes of a name, and names, follow back to back.
// Reset (asynchronous, active low) empties both registers and sets the match state to
// position zero, all known names still candidates and no overlong flag.
`default_nettype none

module http_header_name_classifier (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [hhnc_pkg::BYTE_W-1:0]   name_byte,
	input  wire logic                          final_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [hhnc_pkg::KIND_W-1:0]   header_kind
);
	import hhnc_pkg::*;

	logic                 valid_s1;
	logic [BYTE_W-1:0]    byte_s1;
	logic                 final_s1;
	logic                 adv;

	logic [POS_W-1:0]     pos_q;
	logic [NUM_KINDS-1:0] mask_q;
	logic                 too_long_q;

	logic [POS_W-1:0]     pos_next;
	logic [NUM_KINDS-1:0] mask_next;
	logic                 too_long_next;
	logic [NUM_KINDS-1:0] keep;
	logic [NUM_KINDS-1:0] ends;
	logic [NUM_KINDS-1:0] hit;
	logic [KIND_W-1:0]    kind;

	logic                 out_valid_q;
	logic [KIND_W-1:0]    kind_q;

	// The held byte moves on unless it ends a name and the result register is blocked.
	assign adv      = !final_s1 || !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;

	hhnc_match u_match (
		.name_byte (byte_s1),
		.pos       (pos_q[4:0]),
		.next_pos  (pos_next),
		.keep      (keep),
		.ends      (ends)
	);

	always_comb begin
		if (pos_q[POS_W-1]) begin
			pos_next      = pos_q;
			mask_next     = mask_q;
			too_long_next = 1'b1;
		end else begin
			pos_next      = pos_q + POS_W'(1);
			mask_next     = mask_q & keep;
			too_long_next = too_long_q;
		end
	end

	// Distinct names cannot both match exactly, so at most one bit of hit is set.
	always_comb begin
		hit  = too_long_next ? '0 : (mask_next & ends);
		kind = '0;
		for (int k = 0; k < NUM_KINDS; k++) begin
			if (hit[k]) begin
				kind = kind | KIND_W'(k + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= name_byte;
			final_s1 <= final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			mask_q     <= '1;
			too_long_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			if (final_s1) begin
				pos_q      <= '0;
				mask_q     <= '1;
				too_long_q <= 1'b0;
			end else begin
				pos_q      <= pos_next;
				mask_q     <= mask_next;
				too_long_q <= too_long_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv && final_s1) begin
			kind_q <= kind;
		end
	end

	assign out_valid   = out_valid_q;
	assign header_kind = kind_q;

endmodule

`default_nettype wire
